### hdl/attribute_cell_color_reducer_assert.svh
// Assertion macros for the attribute cell colour reducer.
`ifndef ATTRIBUTE_CELL_COLOR_REDUCER_ASSERT_SVH
`define ATTRIBUTE_CELL_COLOR_REDUCER_ASSERT_SVH

// Check that a condition holds in the same cycle as its trigger.
`define ACCR_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("attribute cell colour reducer check failed");

// Check that a condition holds in the cycle after its trigger.
`define ACCR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("attribute cell colour reducer check failed");

`endif

### hdl/accr_pkg.sv
// Shared types, constants, the black-alias folding function and the selection function for the colour reducer.
package accr_pkg;

  localparam int PixCount = 8;
  localparam int NumIndex = 16;
  localparam int IdxW     = 4;
  localparam int CntW     = 4;
  localparam int ColW     = 5;
  localparam int RowW     = 8;
  localparam int PatW     = 8;
  localparam int AttrW    = 7;
  localparam int Levels   = $clog2(NumIndex);

  localparam logic [IdxW-1:0] BlackAlias  = 4'd8;
  localparam logic [IdxW-1:0] BlackIndex  = 4'd0;
  localparam logic [IdxW-1:0] BrightLimit = 4'd7;

  typedef logic [PixCount-1:0][IdxW-1:0] pix_arr_t;
  typedef logic [NumIndex-1:0][CntW-1:0] cnt_arr_t;

  typedef struct packed {
    logic [CntW-1:0] cnt;
    logic [IdxW-1:0] idx;
  } pick_t;

  function automatic logic [IdxW-1:0] norm_index(logic [IdxW-1:0] p);
    return (p == BlackAlias) ? BlackIndex : p;
  endfunction

  // Pairwise tree over all counts; on equal counts keep the higher or lower index.
  function automatic pick_t pick_max(cnt_arr_t c, logic prefer_high);
    pick_t node [NumIndex];
    pick_t lo;
    pick_t hi;
    logic  take_hi;
    for (int j = 0; j < NumIndex; j++) begin
      node[j].cnt = c[j];
      node[j].idx = IdxW'(j);
    end
    for (int lvl = 0; lvl < Levels; lvl++) begin
      for (int j = 0; j < NumIndex / 2; j++) begin
        if (j < (NumIndex >> (lvl + 1))) begin
          lo = node[2*j];
          hi = node[2*j+1];
          take_hi = prefer_high ? (hi.cnt >= lo.cnt) : (hi.cnt > lo.cnt);
          node[j] = take_hi ? hi : lo;
        end
      end
    end
    return node[0];
  endfunction

endpackage

### hdl/attribute_cell_color_reducer.sv
// Top level of the attribute cell colour reducer.
//
// Takes one eight-pixel cell per clock while in_stall is low. The ink mask and
// attribute appear on the outputs after four register stages: index counting,
// ink choice, paper choice and final encoding. Each stage holds its request
// only while the next one is full and stalled, so bubbles close up and a stall
// on the output reaches in_stall only once every stage is occupied. Palette
// index 8 is treated as black, the same as 0.
`include "attribute_cell_color_reducer_assert.svh"

module attribute_cell_color_reducer import accr_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [IdxW-1:0]  pix0,
  input  logic [IdxW-1:0]  pix1,
  input  logic [IdxW-1:0]  pix2,
  input  logic [IdxW-1:0]  pix3,
  input  logic [IdxW-1:0]  pix4,
  input  logic [IdxW-1:0]  pix5,
  input  logic [IdxW-1:0]  pix6,
  input  logic [IdxW-1:0]  pix7,
  input  logic [ColW-1:0]  cell_col,
  input  logic [RowW-1:0]  cell_row,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [PatW-1:0]  pattern,
  output logic [AttrW-1:0] attribute,
  output logic [IdxW-1:0]  ink_index,
  output logic [IdxW-1:0]  paper_index,
  output logic [ColW-1:0]  out_col,
  output logic [RowW-1:0]  out_row
);

  pix_arr_t        in_pix;

  logic            c_valid;
  logic            c_stall;
  pix_arr_t        c_pix;
  cnt_arr_t        c_cnt;
  logic [ColW-1:0] c_col;
  logic [RowW-1:0] c_row;

  logic            i_valid;
  logic            i_stall;
  pix_arr_t        i_pix;
  cnt_arr_t        i_cnt;
  logic [IdxW-1:0] i_ink;
  logic [ColW-1:0] i_col;
  logic [RowW-1:0] i_row;

  logic            p_valid;
  logic            p_stall;
  pix_arr_t        p_pix;
  logic [IdxW-1:0] p_ink;
  logic [IdxW-1:0] p_paper;
  logic [ColW-1:0] p_col;
  logic [RowW-1:0] p_row;

  assign in_pix = {pix7, pix6, pix5, pix4, pix3, pix2, pix1, pix0};

  accr_count u_count (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_pix    (in_pix),
    .in_col    (cell_col),
    .in_row    (cell_row),
    .out_valid (c_valid),
    .out_stall (c_stall),
    .pix       (c_pix),
    .cnt       (c_cnt),
    .col       (c_col),
    .row       (c_row)
  );

  accr_ink u_ink (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (c_valid),
    .in_stall  (c_stall),
    .in_pix    (c_pix),
    .in_cnt    (c_cnt),
    .in_col    (c_col),
    .in_row    (c_row),
    .out_valid (i_valid),
    .out_stall (i_stall),
    .pix       (i_pix),
    .cnt       (i_cnt),
    .ink       (i_ink),
    .col       (i_col),
    .row       (i_row)
  );

  accr_paper u_paper (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (i_valid),
    .in_stall  (i_stall),
    .in_pix    (i_pix),
    .in_cnt    (i_cnt),
    .in_ink    (i_ink),
    .in_col    (i_col),
    .in_row    (i_row),
    .out_valid (p_valid),
    .out_stall (p_stall),
    .pix       (p_pix),
    .ink       (p_ink),
    .paper     (p_paper),
    .col       (p_col),
    .row       (p_row)
  );

  accr_encode u_encode (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (p_valid),
    .in_stall  (p_stall),
    .in_pix    (p_pix),
    .in_ink    (p_ink),
    .in_paper  (p_paper),
    .in_col    (p_col),
    .in_row    (p_row),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .pattern   (pattern),
    .attribute (attribute),
    .ink       (ink_index),
    .paper     (paper_index),
    .col       (out_col),
    .row       (out_row)
  );

  `ACCR_ASSERT_SAME(a_no_alias_out, out_valid, (ink_index != BlackAlias) && (paper_index != BlackAlias))
  `ACCR_ASSERT_SAME(a_black_cell, out_valid && (ink_index == BlackIndex), (pattern == '0) && (paper_index == BlackIndex))
  `ACCR_ASSERT_SAME(a_paper_differs, out_valid && (ink_index != BlackIndex), paper_index != ink_index)
  `ACCR_ASSERT_NEXT(a_paper_stage_holds, p_valid && p_stall, p_valid && $stable(p_paper) && $stable(p_ink))

endmodule

### hdl/accr_count.sv
// First stage: fold black alias and count each palette index in the cell.
module accr_count import accr_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  pix_arr_t        in_pix,
  input  logic [ColW-1:0] in_col,
  input  logic [RowW-1:0] in_row,
  output logic            out_valid,
  input  logic            out_stall,
  output pix_arr_t        pix,
  output cnt_arr_t        cnt,
  output logic [ColW-1:0] col,
  output logic [RowW-1:0] row
);

  pix_arr_t pix_next;
  cnt_arr_t cnt_next;
  logic     hold;

  assign hold     = out_valid && out_stall;
  assign in_stall = hold;

  always_comb begin
    for (int i = 0; i < PixCount; i++) begin
      pix_next[i] = norm_index(in_pix[i]);
    end
    for (int k = 0; k < NumIndex; k++) begin
      cnt_next[k] = '0;
      for (int i = 0; i < PixCount; i++) begin
        cnt_next[k] = cnt_next[k] + CntW'(pix_next[i] == IdxW'(k));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!hold) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!hold && in_valid) begin
      pix <= pix_next;
      cnt <= cnt_next;
      col <= in_col;
      row <= in_row;
    end
  end

endmodule

### hdl/accr_ink.sv
// Second stage: choose the ink and clear its count.
module accr_ink import accr_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  pix_arr_t        in_pix,
  input  cnt_arr_t        in_cnt,
  input  logic [ColW-1:0] in_col,
  input  logic [RowW-1:0] in_row,
  output logic            out_valid,
  input  logic            out_stall,
  output pix_arr_t        pix,
  output cnt_arr_t        cnt,
  output logic [IdxW-1:0] ink,
  output logic [ColW-1:0] col,
  output logic [RowW-1:0] row
);

  cnt_arr_t        no_black;
  pick_t           best;
  logic [IdxW-1:0] ink_next;
  cnt_arr_t        cnt_next;
  logic            hold;

  assign hold     = out_valid && out_stall;
  assign in_stall = hold;

  always_comb begin
    no_black             = in_cnt;
    no_black[BlackIndex] = '0;
    best                 = pick_max(no_black, 1'b1);
    ink_next             = (best.cnt == '0) ? BlackIndex : best.idx;
    cnt_next             = in_cnt;
    if (ink_next != BlackIndex) begin
      cnt_next[ink_next] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!hold) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!hold && in_valid) begin
      pix <= in_pix;
      cnt <= cnt_next;
      ink <= ink_next;
      col <= in_col;
      row <= in_row;
    end
  end

endmodule

### hdl/accr_paper.sv
// Third stage: choose the paper from the remaining counts.
module accr_paper import accr_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  pix_arr_t        in_pix,
  input  cnt_arr_t        in_cnt,
  input  logic [IdxW-1:0] in_ink,
  input  logic [ColW-1:0] in_col,
  input  logic [RowW-1:0] in_row,
  output logic            out_valid,
  input  logic            out_stall,
  output pix_arr_t        pix,
  output logic [IdxW-1:0] ink,
  output logic [IdxW-1:0] paper,
  output logic [ColW-1:0] col,
  output logic [RowW-1:0] row
);

  pick_t best;
  logic  hold;

  assign hold     = out_valid && out_stall;
  assign in_stall = hold;
  assign best     = pick_max(in_cnt, 1'b0);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!hold) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!hold && in_valid) begin
      pix   <= in_pix;
      ink   <= in_ink;
      paper <= (best.cnt == '0) ? BlackIndex : best.idx;
      col   <= in_col;
      row   <= in_row;
    end
  end

endmodule

### hdl/accr_encode.sv
// Fourth stage: build the ink mask and the seven-bit attribute.
module accr_encode import accr_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  pix_arr_t         in_pix,
  input  logic [IdxW-1:0]  in_ink,
  input  logic [IdxW-1:0]  in_paper,
  input  logic [ColW-1:0]  in_col,
  input  logic [RowW-1:0]  in_row,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [PatW-1:0]  pattern,
  output logic [AttrW-1:0] attribute,
  output logic [IdxW-1:0]  ink,
  output logic [IdxW-1:0]  paper,
  output logic [ColW-1:0]  col,
  output logic [RowW-1:0]  row
);

  logic [PatW-1:0]  pattern_next;
  logic [AttrW-1:0] attribute_next;
  logic             hold;

  assign hold     = out_valid && out_stall;
  assign in_stall = hold;

  always_comb begin
    for (int i = 0; i < PixCount; i++) begin
      pattern_next[PatW-1-i] = (in_ink != BlackIndex) &&
                               ((in_pix[i] == in_ink) || (in_pix[i] != in_paper));
    end
    attribute_next = {in_ink > BrightLimit, in_paper[2:0], in_ink[2:0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!hold) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!hold && in_valid) begin
      pattern   <= pattern_next;
      attribute <= attribute_next;
      ink       <= in_ink;
      paper     <= in_paper;
      col       <= in_col;
      row       <= in_row;
    end
  end

endmodule

### tb/accr_cell_checker.sv
// Checker for the attribute cell colour reducer: predicts each cell and compares the results.
`timescale 1ns / 100ps

module accr_cell_checker import accr_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_stall,
  input  logic [IdxW-1:0]  pix0,
  input  logic [IdxW-1:0]  pix1,
  input  logic [IdxW-1:0]  pix2,
  input  logic [IdxW-1:0]  pix3,
  input  logic [IdxW-1:0]  pix4,
  input  logic [IdxW-1:0]  pix5,
  input  logic [IdxW-1:0]  pix6,
  input  logic [IdxW-1:0]  pix7,
  input  logic [ColW-1:0]  cell_col,
  input  logic [RowW-1:0]  cell_row,
  input  logic             out_valid,
  input  logic             out_stall,
  input  logic [PatW-1:0]  pattern,
  input  logic [AttrW-1:0] attribute,
  input  logic [IdxW-1:0]  ink_index,
  input  logic [IdxW-1:0]  paper_index,
  input  logic [ColW-1:0]  out_col,
  input  logic [RowW-1:0]  out_row,
  output int               fail_count,
  output int               pending
);

  localparam int ReportLimit = 10;

  typedef struct packed {
    logic [PatW-1:0]  pat;
    logic [AttrW-1:0] attr;
    logic [IdxW-1:0]  ink;
    logic [IdxW-1:0]  paper;
    logic [ColW-1:0]  col;
    logic [RowW-1:0]  row;
  } shade_t;

  shade_t expected_cells[$];

  function automatic shade_t reduce_cell(pix_arr_t p, logic [ColW-1:0] col,
                                         logic [RowW-1:0] row);
    logic [IdxW-1:0] q [PixCount];
    int              tally [NumIndex];
    int              ink_n;
    int              paper_n;
    logic [IdxW-1:0] ink;
    logic [IdxW-1:0] paper;
    shade_t          r;
    ink     = BlackIndex;
    paper   = BlackIndex;
    ink_n   = 0;
    paper_n = 0;
    for (int i = 0; i < NumIndex; i++) tally[i] = 0;
    for (int i = 0; i < PixCount; i++) begin
      q[i] = (p[i] == BlackAlias) ? BlackIndex : p[i];
      tally[q[i]]++;
    end
    for (int i = 1; i < NumIndex; i++) begin
      if (tally[i] != 0 && tally[i] >= ink_n) begin
        ink_n = tally[i];
        ink   = IdxW'(i);
      end
    end
    if (ink != BlackIndex) tally[ink] = 0;
    for (int i = 0; i < NumIndex; i++) begin
      if (tally[i] > paper_n) begin
        paper_n = tally[i];
        paper   = IdxW'(i);
      end
    end
    r.pat = '0;
    for (int i = 0; i < PixCount; i++) begin
      if (ink != BlackIndex && (q[i] == ink || q[i] != paper)) r.pat[PatW-1-i] = 1'b1;
    end
    r.attr  = {(ink > BrightLimit), paper[2:0], ink[2:0]};
    r.ink   = ink;
    r.paper = paper;
    r.col   = col;
    r.row   = row;
    return r;
  endfunction

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  always @(posedge clk) begin : watch
    shade_t got;
    shade_t want;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        expected_cells.push_back(reduce_cell({pix7, pix6, pix5, pix4, pix3, pix2, pix1, pix0},
                                             cell_col, cell_row));
      end
      if (out_valid && !out_stall) begin
        got = '{pattern, attribute, ink_index, paper_index, out_col, out_row};
        if (expected_cells.size() == 0) begin
          if (fail_count < ReportLimit)
            $display("%0t: result with no request outstanding: pat %h attr %h", $realtime,
                     got.pat, got.attr);
          fail_count++;
        end else begin
          want = expected_cells.pop_front();
          if (got.pat !== want.pat || got.attr !== want.attr || got.ink !== want.ink ||
              got.paper !== want.paper || got.col !== want.col || got.row !== want.row) begin
            if (fail_count < ReportLimit) begin
              $display("%0t: mismatch exp pat %h attr %h ink %0d paper %0d col %0d row %0d",
                       $realtime, want.pat, want.attr, want.ink, want.paper, want.col,
                       want.row);
              $display("%0t:          got pat %h attr %h ink %0d paper %0d col %0d row %0d",
                       $realtime, got.pat, got.attr, got.ink, got.paper, got.col, got.row);
            end
            fail_count++;
          end
        end
      end
      pending = expected_cells.size();
    end
  end

endmodule

### tb/tb_attribute_cell_color_reducer.sv
// Testbench top for the attribute cell colour reducer: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_attribute_cell_color_reducer;
  import accr_pkg::*;

  localparam int RandomCells = 1630;
  localparam int QuietCells  = 150;
  localparam int HoldAt      = 400;
  localparam int HoldCycles  = 60;

  typedef struct packed {
    pix_arr_t        pix;
    logic [ColW-1:0] col;
    logic [RowW-1:0] row;
  } cell_t;

  logic             clk = 1'b0;
  logic             rst;
  logic             in_valid;
  logic             in_stall;
  logic [IdxW-1:0]  pix0, pix1, pix2, pix3, pix4, pix5, pix6, pix7;
  logic [ColW-1:0]  cell_col;
  logic [RowW-1:0]  cell_row;
  logic             out_valid;
  logic             out_stall;
  logic [PatW-1:0]  pattern;
  logic [AttrW-1:0] attribute;
  logic [IdxW-1:0]  ink_index;
  logic [IdxW-1:0]  paper_index;
  logic [ColW-1:0]  out_col;
  logic [RowW-1:0]  out_row;
  int               fail_count;
  int               pending;

  logic hold_go   = 1'b0;
  logic hold_done = 1'b0;
  logic quiet     = 1'b0;

  attribute_cell_color_reducer dut (.*);
  accr_cell_checker checker_i (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic cell_t cell_of(logic [31:0] hues, logic [ColW-1:0] col,
                                     logic [RowW-1:0] row);
    cell_t c;
    for (int i = 0; i < PixCount; i++) c.pix[i] = hues[31-4*i -: 4];
    c.col = col;
    c.row = row;
    return c;
  endfunction

  function automatic cell_t random_cell();
    cell_t           c;
    logic [IdxW-1:0] hue [3];
    logic [IdxW-1:0] t;
    int              kind;
    int              j;
    kind = $urandom_range(0, 9);
    for (int k = 0; k < 3; k++) hue[k] = IdxW'($urandom_range(0, NumIndex - 1));
    for (int k = 0; k < PixCount; k++) begin
      case (kind)
        0, 1, 2: c.pix[k] = IdxW'($urandom);
        3, 4:    c.pix[k] = hue[$urandom_range(0, 1)];
        5, 6:    c.pix[k] = hue[$urandom_range(0, 2)];
        7:       c.pix[k] = $urandom_range(0, 1) ? hue[0] :
                            ($urandom_range(0, 1) ? BlackAlias : BlackIndex);
        8:       c.pix[k] = (k < 4) ? hue[0] : hue[1];
        default: c.pix[k] = $urandom_range(0, 1) ? BlackAlias : BlackIndex;
      endcase
    end
    if (kind == 8) begin
      for (int k = PixCount - 1; k > 0; k--) begin
        j        = $urandom_range(0, k);
        t        = c.pix[k];
        c.pix[k] = c.pix[j];
        c.pix[j] = t;
      end
    end
    if ($urandom_range(0, 15) == 0) begin
      c.col = $urandom_range(0, 1) ? '1 : '0;
      c.row = $urandom_range(0, 1) ? '1 : '0;
    end else begin
      c.col = ColW'($urandom);
      c.row = RowW'($urandom);
    end
    return c;
  endfunction

  task automatic send_cell(input cell_t c);
    in_valid = 1'b1;
    pix0     = c.pix[0];
    pix1     = c.pix[1];
    pix2     = c.pix[2];
    pix3     = c.pix[3];
    pix4     = c.pix[4];
    pix5     = c.pix[5];
    pix6     = c.pix[6];
    pix7     = c.pix[7];
    cell_col = c.col;
    cell_row = c.row;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin : time_limit
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin : result_side
    out_stall = 1'b0;
    wait (rst === 1'b0);
    forever begin
      @(negedge clk);
      if (hold_go && !hold_done) begin
        out_stall = 1'b1;
        repeat (HoldCycles - 1) @(negedge clk);
        hold_done = 1'b1;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(0, 6)) @(negedge clk);
      end else begin
        out_stall = 1'b0;
        repeat ($urandom_range(0, 15)) @(negedge clk);
      end
    end
  end

  initial begin : request_side
    logic [31:0] directed [20];
    rst      = 1'b1;
    in_valid = 1'b0;
    pix0     = '0;
    pix1     = '0;
    pix2     = '0;
    pix3     = '0;
    pix4     = '0;
    pix5     = '0;
    pix6     = '0;
    pix7     = '0;
    cell_col = '0;
    cell_row = '0;
    directed = '{32'h0000_0000, 32'h8888_8888, 32'h0808_8080, 32'hFFFF_FFFF,
                 32'h5050_0555, 32'h0123_4567, 32'h89AB_CDEF, 32'h3333_CCCC,
                 32'h9962_9926, 32'h0707_0707, 32'h1124_2142, 32'h8188_1881,
                 32'h7777_7777, 32'h9999_9999, 32'hF1F1_F1F1, 32'hEDCB_A980,
                 32'h4444_4445, 32'h5444_4444, 32'hFEDC_BA98, 32'h2288_2288};
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    foreach (directed[k]) begin
      send_cell(cell_of(directed[k], (k % 2) ? '1 : '0, (k % 2) ? '1 : '0));
    end
    for (int sent = 0; sent < RandomCells; sent++) begin
      if (sent == HoldAt) hold_go = 1'b1;
      if (sent == RandomCells - QuietCells) quiet = 1'b1;
      send_cell(random_cell());
      if (!quiet && !(hold_go && !hold_done) && ((sent / 128) % 3) != 2 &&
          $urandom_range(0, 3) == 0) begin
        in_valid = 1'b0;
        repeat ($urandom_range(1, 7)) @(negedge clk);
      end
    end
    in_valid = 1'b0;
    wait (pending == 0);
    repeat (12) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
